// ----- src/mco_pkg.sv -----
`timescale 1ns / 1ps
package mco_pkg;
    localparam int MAX_MATRICES = 16;
    localparam int DIM_BITS = 16;
    localparam int DIM_CAP = MAX_MATRICES + 1;
    localparam int IDX_BITS = 4;
    localparam int CNT_BITS = 6;
    localparam int COST_BITS = 63;
    localparam int ADDR_BITS = 2 * IDX_BITS;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    localparam logic [1:0] KIND_COST = 2'd0;
    localparam logic [1:0] KIND_OPEN = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_MATRIX = 2'd3;

    // one result transaction
    typedef struct packed {
        logic [1:0]           kind;
        logic [IDX_BITS-1:0]  matrix_index;
        logic [COST_BITS-1:0] cost;
        logic                 error;
        logic                 end_of_run;
    } result_t;
endpackage

// ----- src/matrix_chain_order_top.sv -----
`timescale 1ns / 1ps
// dimensions load one per cycle while no result is pending; after the last one S_DIAG
// writes the diagonal, then each (i,k,j) triple runs S_RD1, S_RD2, S_MUL1, S_MUL2, S_CMP
// on one shared 16-bit-slice multiplier, O(n^3), plus one table write per interval
// the token walk gives a matrix or close token from S_WPOP and S_WALK, an open from all six walk states
// input is not ready from the last dimension until the final result is taken
// rst_n is asynchronous and active low; tables are written before read
module matrix_chain_order_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // dim
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // matrix_index, cost, error, pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);
    import mco_pkg::*;

    result_t res;

    mco_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_dim   (s_axis_tdata[DIM_BITS-1:0]),
        .in_last  (s_axis_tlast),
        .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready),
        .res      (res)
    );

    assign m_axis_tdata = {4'd0, res.error, res.cost, res.matrix_index};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.end_of_run;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.error) |-> m_axis_tlast) else $error("error not final");
`endif
endmodule

// ----- src/mco_mul.sv -----
`timescale 1ns / 1ps
module mco_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mco_pkg::COST_BITS-1:0] a,
    input  logic [15:0]                   b,
    output logic                          done,
    output logic [mco_pkg::COST_BITS-1:0] p
);
    import mco_pkg::*;

    // saturating 63x16 multiply, 16 bits of a per cycle
    logic [2:0]           step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic [COST_BITS-1:0] a_reg, a_next;
    logic [15:0]          b_reg, b_next;
    logic [80:0]          acc_reg, acc_next;
    logic                 done_reg, done_next;
    logic [31:0]          part;
    logic [80:0]          shifted;

    assign part = {16'd0, a_reg[15:0]} * {16'd0, b_reg};

    always_comb
    begin
        shifted = {49'd0, part} << (6'(step_reg) * 6'd16);
        step_next = step_reg;
        busy_next = busy_reg;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            a_next = a;
            b_next = b;
            acc_next = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + shifted;
            a_next = {16'd0, a_reg[COST_BITS-1:16]};
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign p = (acc_reg[80:63] != '0) ? COST_MAX : acc_reg[62:0];
endmodule

// ----- src/mco_core.sv -----
`timescale 1ns / 1ps
module mco_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mco_pkg::DIM_BITS-1:0]        in_dim,
    input  logic                                in_last,
    output logic                                res_valid,
    input  logic                                res_ready,
    output mco_pkg::result_t                    res
);
    import mco_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_DIAG = 4'd1;
    localparam logic [3:0] S_RD1 = 4'd2;
    localparam logic [3:0] S_RD2 = 4'd3;
    localparam logic [3:0] S_MUL1 = 4'd4;
    localparam logic [3:0] S_MUL2 = 4'd5;
    localparam logic [3:0] S_CMP = 4'd6;
    localparam logic [3:0] S_WR = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_WRD = 4'd9;
    localparam logic [3:0] S_WALK = 4'd10;
    localparam logic [3:0] S_WSPL = 4'd11;
    localparam logic [3:0] S_WPOP = 4'd12;
    localparam logic [3:0] S_WCLS = 4'd13;
    localparam logic [3:0] S_WRGT = 4'd14;
    localparam logic [3:0] S_WLFT = 4'd15;

    // walk stack entry codes: {tag, i, j}
    localparam logic [1:0] TAG_IV = 2'd0;
    localparam logic [1:0] TAG_CL = 2'd1;

    logic [DIM_BITS-1:0]  dim_mem [DIM_CAP];
    logic [COST_BITS-1:0] cost_mem [1 << ADDR_BITS];
    logic [IDX_BITS-1:0]  split_mem [1 << ADDR_BITS];
    logic [9:0]           stack_mem [2 * MAX_MATRICES];

    logic [3:0]           state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]  nm1_reg, nm1_next;
    logic [IDX_BITS:0]    len_reg, len_next;
    logic [IDX_BITS-1:0]  i_reg, i_next, k_reg, k_next, bk_reg, bk_next;
    logic [COST_BITS-1:0] best_reg, best_next, sum_reg, sum_next;
    logic [5:0]           sp_reg, sp_next;
    result_t              res_reg, res_next;
    logic                 rv_reg, rv_next;
    logic                 mph_reg, mph_next;
    logic [IDX_BITS-1:0]  j_w;
    logic [IDX_BITS:0]    jt;

    // memory ports
    logic [ADDR_BITS-1:0] c_raddr;
    logic [COST_BITS-1:0] c_rdata;
    logic                 c_we;
    logic [ADDR_BITS-1:0] c_waddr;
    logic [COST_BITS-1:0] c_wdata;
    logic [IDX_BITS-1:0]  s_wdata, s_rdata;
    logic [DIM_BITS-1:0]  d_rdata;
    logic [IDX_BITS-1:0]  d_raddr_s;
    logic [4:0]           d_raddr;
    logic                 st_we;
    logic [4:0]           st_waddr;
    logic [9:0]           st_wdata, st_rdata;

    logic                 m_start, m_done;
    logic [COST_BITS-1:0] m_a, m_p, m_a_reg, m_a_next;
    logic [COST_BITS:0]   add_s;
    logic [COST_BITS-1:0] add_a, add_b, add_sat;

    // walk temp
    logic [IDX_BITS-1:0]  wi_reg, wi_next, wj_reg, wj_next;

    assign jt = {1'b0, i_reg} + len_reg - 5'd1;
    assign j_w = jt[IDX_BITS-1:0];
    assign add_s = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat = add_s[COST_BITS] ? COST_MAX : add_s[COST_BITS-1:0];

    mco_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(m_start),
        .a    (m_a),
        .b    (d_rdata),
        .done (m_done),
        .p    (m_p)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && in_valid && in_ready && cnt_reg < CNT_BITS'(DIM_CAP))
            dim_mem[cnt_reg[4:0]] <= in_dim;
        d_rdata <= dim_mem[d_raddr];
        if (c_we)
        begin
            cost_mem[c_waddr] <= c_wdata;
            split_mem[c_waddr] <= s_wdata;
        end
        c_rdata <= cost_mem[c_raddr];
        s_rdata <= split_mem[c_raddr];
        if (st_we)
            stack_mem[st_waddr] <= st_wdata;
        st_rdata <= stack_mem[sp_reg[4:0] - 5'd1];
    end

    assign in_ready = (state_reg == S_LOAD) && !rv_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        nm1_next = nm1_reg;
        len_next = len_reg;
        i_next = i_reg;
        k_next = k_reg;
        bk_next = bk_reg;
        best_next = best_reg;
        sum_next = sum_reg;
        sp_next = sp_reg;
        res_next = res_reg;
        rv_next = rv_reg;
        mph_next = mph_reg;
        wi_next = wi_reg;
        wj_next = wj_reg;
        m_a_next = m_a_reg;
        m_a = m_a_reg;
        m_start = 1'b0;
        c_raddr = {i_reg, k_reg};
        c_we = 1'b0;
        c_waddr = {i_reg, i_reg};
        c_wdata = '0;
        s_wdata = i_reg;
        d_raddr_s = i_reg;
        d_raddr = {1'b0, d_raddr_s};
        st_we = 1'b0;
        st_waddr = sp_reg[4:0];
        st_wdata = '0;
        add_a = sum_reg;
        add_b = c_rdata;
        if (rv_reg && res_ready)
            rv_next = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_ready)
                begin
                    if (cnt_reg < CNT_BITS'(DIM_CAP + 1))
                        cnt_next = cnt_reg + 1'b1;
                    if (in_last)
                    begin
                        cnt_next = '0;
                        if (cnt_reg == '0 || cnt_reg >= CNT_BITS'(DIM_CAP))
                        begin
                            res_next = '{KIND_COST, '0, '0, 1'b1, 1'b1};
                            rv_next = 1'b1;
                        end
                        else
                        begin
                            nm1_next = IDX_BITS'(cnt_reg - 1'b1);
                            i_next = '0;
                            state_next = S_DIAG;
                        end
                    end
                end
            end
            S_DIAG:
            begin
                c_we = 1'b1;
                if (i_reg == nm1_reg)
                begin
                    len_next = 5'd2;
                    i_next = '0;
                    k_next = '0;
                    state_next = (nm1_reg == '0) ? S_OUT : S_RD1;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_RD1:
            begin
                // read cost[i][k] and dim[i]
                c_raddr = {i_reg, k_reg};
                d_raddr = {1'b0, i_reg};
                state_next = S_RD2;
            end
            S_RD2:
            begin
                c_raddr = {k_reg + 1'b1, j_w};
                d_raddr = 5'({1'b0, k_reg} + 5'd1);
                sum_next = c_rdata;
                m_a_next = {47'd0, d_rdata};
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                // c_rdata is cost[k+1][j], d_rdata is dim[k+1]
                add_a = sum_reg;
                add_b = c_rdata;
                sum_next = add_sat;
                m_start = 1'b1;
                mph_next = 1'b0;
                d_raddr = 5'(jt + 5'd1);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                d_raddr = 5'(jt + 5'd1);
                if (m_done)
                begin
                    // second pass multiplies the first product by dim[j+1]
                    if (mph_reg)
                        state_next = S_CMP;
                    else
                    begin
                        mph_next = 1'b1;
                        m_a = m_p;
                        m_start = 1'b1;
                    end
                end
            end
            S_CMP:
            begin
                add_a = sum_reg;
                add_b = m_p;
                if (k_reg == i_reg || add_sat < best_reg)
                begin
                    best_next = add_sat;
                    bk_next = k_reg;
                end
                if (k_reg + 1'b1 == j_w)
                    state_next = S_WR;
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_RD1;
                end
            end
            S_WR:
            begin
                c_we = 1'b1;
                c_waddr = {i_reg, j_w};
                c_wdata = best_reg;
                s_wdata = bk_reg;
                if (jt == {1'b0, nm1_reg})
                begin
                    if (len_reg == {1'b0, nm1_reg} + 5'd1)
                        state_next = S_OUT;
                    else
                    begin
                        len_next = len_reg + 1'b1;
                        i_next = '0;
                        k_next = '0;
                        state_next = S_RD1;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    k_next = i_reg + 1'b1;
                    state_next = S_RD1;
                end
            end
            S_OUT:
            begin
                c_raddr = {IDX_BITS'(0), nm1_reg};
                state_next = S_WRD;
            end
            S_WRD:
            begin
                if (!rv_reg)
                begin
                    res_next = '{KIND_COST, '0, c_rdata, 1'b0, 1'b0};
                    rv_next = 1'b1;
                    st_we = 1'b1;
                    st_waddr = 5'd0;
                    st_wdata = {TAG_IV, IDX_BITS'(0), nm1_reg};
                    sp_next = 6'd1;
                    state_next = S_WPOP;
                end
            end
            S_WPOP:
            begin
                // stack top is read into a register here, once sp has settled
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (!rv_reg || res_ready)
                begin
                    wi_next = st_rdata[7:4];
                    wj_next = st_rdata[3:0];
                    if (st_rdata[9:8] == TAG_CL)
                    begin
                        res_next = '{KIND_CLOSE, '0, '0, 1'b0, sp_reg == 6'd1};
                        rv_next = 1'b1;
                        sp_next = sp_reg - 1'b1;
                        state_next = (sp_reg == 6'd1) ? S_LOAD : S_WPOP;
                    end
                    else if (st_rdata[7:4] >= st_rdata[3:0])
                    begin
                        res_next = '{KIND_MATRIX, st_rdata[7:4], '0, 1'b0, sp_reg == 6'd1};
                        rv_next = 1'b1;
                        sp_next = sp_reg - 1'b1;
                        state_next = (sp_reg == 6'd1) ? S_LOAD : S_WPOP;
                    end
                    else
                    begin
                        res_next = '{KIND_OPEN, '0, '0, 1'b0, 1'b0};
                        rv_next = 1'b1;
                        state_next = S_WSPL;
                    end
                end
            end
            S_WSPL:
            begin
                c_raddr = {wi_reg, wj_reg};
                state_next = S_WCLS;
            end
            S_WCLS:
            begin
                // clamp the split and turn the top entry into its close
                k_next = (s_rdata < wi_reg || s_rdata >= wj_reg) ? wi_reg : s_rdata;
                st_we = 1'b1;
                st_waddr = 5'(sp_reg - 6'd1);
                st_wdata = {TAG_CL, wi_reg, wj_reg};
                state_next = S_WRGT;
            end
            S_WRGT:
            begin
                // push the right part
                st_we = 1'b1;
                st_waddr = sp_reg[4:0];
                st_wdata = {TAG_IV, k_reg + 1'b1, wj_reg};
                sp_next = sp_reg + 1'b1;
                state_next = S_WLFT;
            end
            S_WLFT:
            begin
                // push the left part on top
                st_we = 1'b1;
                st_waddr = sp_reg[4:0];
                st_wdata = {TAG_IV, wi_reg, k_reg};
                sp_next = sp_reg + 1'b1;
                state_next = S_WPOP;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg <= '0;
            rv_reg <= 1'b0;
            sp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rv_reg <= rv_next;
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm1_reg <= nm1_next;
        len_reg <= len_next;
        i_reg <= i_next;
        k_reg <= k_next;
        bk_reg <= bk_next;
        best_reg <= best_next;
        sum_reg <= sum_next;
        res_reg <= res_next;
        mph_reg <= mph_next;
        wi_reg <= wi_next;
        wj_reg <= wj_next;
        m_a_reg <= m_a_next;
    end

    assign res_valid = rv_reg;
    assign res = res_reg;
endmodule
